[hw/rtl/page_run_allocator_next_best_fit_defines.svh]
// Assertion macros for the page run allocator.
// Used by page_run_allocator_next_best_fit.sv; expects aclk and aresetn in scope.
`ifndef PAGE_RUN_ALLOCATOR_NEXT_BEST_FIT_DEFINES_SVH
`define PAGE_RUN_ALLOCATOR_NEXT_BEST_FIT_DEFINES_SVH

// Checked only outside reset.
`define PRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define PRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/pra_pkg.sv]
// Shared constants for the page run allocator.
// No dependencies.
package pra_pkg;
    localparam int DEF_HEAP_PAGES  = 4096;
    localparam int DEF_MAX_RECORDS = 256;
    localparam int DEF_PAGE_BYTES  = 4096;
    localparam int MAP_W           = 8;    // bitmap bits per memory word
    localparam int CFG_AW          = 1;

    localparam logic [CFG_AW-1:0] REG_FIT_MODE  = 1'd0;
    localparam logic [CFG_AW-1:0] REG_HEAP_BASE = 1'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam logic FIT_NEXT = 1'b0;
    localparam logic FIT_BEST = 1'b1;
endpackage

[hw/rtl/pra_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module pra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/page_run_allocator_next_best_fit.sv]
// Page run allocator: used-page bitmap and allocation records in RAM.
// Depends on pra_pkg, pra_ram and page_run_allocator_next_best_fit_defines.svh.
//
// Use:
//   Input stream s_*: s_tuser is the opcode (0 allocate, 1 free); s_tdata carries
//   request_size (bits 31:0) and release_address (bits 63:32).
//   Result stream m_*: one transfer per input, m_tdata = success, block_address,
//   page_count from bit 0 up. Failures return all fields zero.
//   Config: cfg_we/cfg_addr/cfg_wdata, index 0 fit_mode, index 1 heap_base; write
//   only while idle.
// Sequencing: one item in flight. The record table is scanned one entry per cycle,
//   then the bitmap memory one 8-page word per cycle (two passes worst case in
//   next fit), then each touched bitmap word is read and written back, then the
//   record is written and the result finished. The bitmap read port sets the pace.
// Reset: a clearing pass zeroes both memories; s_tready stays low meanwhile
//   (config writes still taken).
// Stall: the result sits in an output register; the next item is accepted while
//   it waits, and processing only holds at its end if the register is still full.
`include "page_run_allocator_next_best_fit_defines.svh"

module page_run_allocator_next_best_fit
    import pra_pkg::*;
#(
    parameter int HEAP_PAGES  = DEF_HEAP_PAGES,
    parameter int MAX_RECORDS = DEF_MAX_RECORDS,
    parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
    localparam int CW    = $clog2(HEAP_PAGES + 1),
    localparam int OUT_W = ((33 + CW + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // request_size, release_address
    input  logic              s_tuser,   // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // success, block_address, page_count
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [31:0]       cfg_wdata
);
    localparam int PW     = $clog2(HEAP_PAGES);
    localparam int IW     = PW + 1;
    localparam int PB     = $clog2(PAGE_BYTES);
    localparam int MWB    = $clog2(MAP_W);
    localparam int WORDS  = (HEAP_PAGES + MAP_W - 1) / MAP_W;
    localparam int WAW    = $clog2(WORDS);
    localparam int RAW    = $clog2(MAX_RECORDS);
    localparam int REC_W  = 1 + CW + PW;
    localparam int CLR_N  = (WORDS > MAX_RECORDS) ? WORDS : MAX_RECORDS;
    localparam int CLW    = $clog2(CLR_N + 1);
    localparam int PGW    = 32 - PB;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SLOT, ST_SCAN, ST_MARK_RD, ST_MARK_WR, ST_REC_WR, ST_DONE
    } state_t;

    state_t           state_reg;
    logic [CLW-1:0]   clr_reg;
    logic             fit_reg;
    logic [31:0]      base_reg;
    logic [PW-1:0]    cursor_reg;
    logic             op_reg;
    logic [CW-1:0]    cnt_reg;       // pages requested / freed
    logic [PGW-1:0]   page_reg;      // page addressed by a free
    logic [RAW-1:0]   slot_reg;
    logic [PW-1:0]    start_reg;
    logic             ok_reg;
    // record scan
    logic [RAW:0]     ra_reg;
    logic [RAW-1:0]   re_reg;
    logic             rpend_reg;
    // bitmap scan
    logic [WAW:0]     a_reg;
    logic [WAW-1:0]   e_reg;
    logic             pend_reg;
    logic             pass2_reg;
    logic [PW-1:0]    lo_reg;
    logic [CW-1:0]    run_reg;
    logic [PW-1:0]    rs_reg;
    logic             found_reg;
    logic [CW-1:0]    best_reg;
    logic [PW-1:0]    bs_reg;
    // mark
    logic [WAW-1:0]   mw_reg;
    // result
    logic             m_tvalid_reg;
    logic             out_ok_reg;
    logic [31:0]      out_addr_reg;
    logic [CW-1:0]    out_cnt_reg;

    // memories
    logic             map_we;
    logic [WAW-1:0]   map_waddr, map_raddr;
    logic [MAP_W-1:0] map_wdata, map_rdata;
    logic             rec_we;
    logic [RAW-1:0]   rec_waddr;
    logic [REC_W-1:0] rec_wdata, rec_rdata;

    pra_ram #(.WIDTH(MAP_W), .DEPTH(WORDS)) u_map (
        .aclk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    pra_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_rec (
        .aclk, .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(ra_reg[RAW-1:0]), .rdata(rec_rdata)
    );

    // input decode
    logic [32:0]    size_up, pages;
    logic           size_bad;
    logic [31:0]    rel_off;
    assign size_up  = {1'b0, s_tdata[31:0]} + 33'(PAGE_BYTES - 1);
    assign pages    = size_up >> PB;
    assign size_bad = (pages == 33'd0) || (pages > 33'(HEAP_PAGES));
    assign rel_off  = s_tdata[63:32] - base_reg;

    // record entry fields and match
    logic          rec_v;
    logic [CW-1:0] rec_c;
    logic [PW-1:0] rec_s;
    logic [32:0]   rec_lo, rec_hi;
    logic          rec_hit;
    assign rec_v  = rec_rdata[REC_W-1];
    assign rec_c  = rec_rdata[PW +: CW];
    assign rec_s  = rec_rdata[PW-1:0];
    assign rec_lo = 33'(rec_s);
    assign rec_hi = 33'(rec_s) + 33'(rec_c);
    assign rec_hit = (op_reg == OP_ALLOC) ? !rec_v :
                     (rec_v && 33'(page_reg) >= rec_lo && 33'(page_reg) < rec_hi);

    // one bitmap word of the run search
    logic [CW-1:0] st_run, st_b;
    logic [PW-1:0] st_rs, st_bs;
    logic          st_f;
    always_comb begin
        logic [IW-1:0]  pg;
        logic [MWB-1:0] kk;
        logic           fr;
        st_run = run_reg;
        st_rs  = rs_reg;
        st_f   = found_reg;
        st_b   = best_reg;
        st_bs  = bs_reg;
        for (int k = 0; k < MAP_W; k++) begin
            kk = MWB'(k);
            pg = IW'({e_reg, kk});
            fr = !map_rdata[k] && (pg < IW'(HEAP_PAGES)) && (pg >= IW'(lo_reg));
            if (fit_reg == FIT_NEXT) begin
                if (!st_f) begin
                    if (fr) begin
                        if (st_run == '0) st_rs = pg[PW-1:0];
                        st_run = st_run + 1'b1;
                        if (st_run == cnt_reg) begin
                            st_f  = 1'b1;
                            st_bs = st_rs;
                        end
                    end else begin
                        st_run = '0;
                    end
                end
            end else begin
                if (fr) begin
                    if (st_run == '0) st_rs = pg[PW-1:0];
                    st_run = st_run + 1'b1;
                end else begin
                    if (st_run >= cnt_reg && (!st_f || st_run < st_b)) begin
                        st_f  = 1'b1;
                        st_b  = st_run;
                        st_bs = st_rs;
                    end
                    st_run = '0;
                end
            end
        end
    end

    // end of heap for best fit: a run still open counts
    logic best_take;
    assign best_take = (run_reg >= cnt_reg) && (!found_reg || run_reg < best_reg);

    // mark / release mask for the current word
    logic [IW-1:0]    last_pg, cur_sum;
    logic [MAP_W-1:0] mark_mask;
    logic             mark_last;
    assign last_pg = IW'(start_reg) + IW'(cnt_reg) - 1'b1;
    assign cur_sum = IW'(start_reg) + IW'(cnt_reg);
    assign mark_last = (mw_reg == WAW'(last_pg >> MWB));
    always_comb begin
        logic [IW-1:0]  p;
        logic [MWB-1:0] kk;
        for (int k = 0; k < MAP_W; k++) begin
            kk = MWB'(k);
            p  = IW'({mw_reg, kk});
            mark_mask[k] = (p >= IW'(start_reg)) && (p <= last_pg);
        end
    end

    assign map_we    = (state_reg == ST_CLEAR && clr_reg < CLW'(WORDS)) ||
                       (state_reg == ST_MARK_WR);
    assign map_waddr = (state_reg == ST_CLEAR) ? clr_reg[WAW-1:0] : mw_reg;
    assign map_wdata = (state_reg == ST_CLEAR) ? '0 :
                       (op_reg == OP_ALLOC) ? (map_rdata | mark_mask)
                                            : (map_rdata & ~mark_mask);
    assign map_raddr = (state_reg == ST_SCAN) ? a_reg[WAW-1:0] : mw_reg;

    assign rec_we    = (state_reg == ST_CLEAR && clr_reg < CLW'(MAX_RECORDS)) ||
                       (state_reg == ST_REC_WR);
    assign rec_waddr = (state_reg == ST_CLEAR) ? clr_reg[RAW-1:0] : slot_reg;
    assign rec_wdata = (state_reg == ST_CLEAR) ? '0 :
                       {op_reg == OP_ALLOC, cnt_reg, start_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_cnt_reg, out_addr_reg, out_ok_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            fit_reg      <= FIT_NEXT;
            base_reg     <= '0;
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            rpend_reg    <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FIT_MODE:  fit_reg  <= cfg_wdata[0];
                    REG_HEAP_BASE: base_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // ST_DONE reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLW'(CLR_N - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser;
                        cnt_reg   <= CW'(pages);
                        page_reg  <= rel_off[31:PB];
                        ra_reg    <= '0;
                        rpend_reg <= 1'b0;
                        if (s_tuser == OP_ALLOC && size_bad) begin
                            ok_reg    <= 1'b0;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_SLOT;
                        end
                    end
                end
                ST_SLOT: begin
                    if (rpend_reg && rec_hit) begin
                        rpend_reg <= 1'b0;
                        slot_reg  <= re_reg;
                        if (op_reg == OP_ALLOC) begin
                            a_reg     <= (fit_reg == FIT_NEXT) ?
                                         (WAW+1)'(cursor_reg >> MWB) : '0;
                            lo_reg    <= (fit_reg == FIT_NEXT) ? cursor_reg : '0;
                            pend_reg  <= 1'b0;
                            pass2_reg <= 1'b0;
                            run_reg   <= '0;
                            found_reg <= 1'b0;
                            best_reg  <= '0;
                            state_reg <= ST_SCAN;
                        end else begin
                            start_reg <= rec_s;
                            cnt_reg   <= rec_c;
                            mw_reg    <= WAW'(rec_s >> MWB);
                            state_reg <= ST_MARK_RD;
                        end
                    end else if (ra_reg < (RAW+1)'(MAX_RECORDS)) begin
                        re_reg    <= ra_reg[RAW-1:0];
                        ra_reg    <= ra_reg + 1'b1;
                        rpend_reg <= 1'b1;
                    end else if (rpend_reg) begin
                        rpend_reg <= 1'b0;
                    end else begin
                        ok_reg    <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (pend_reg) begin
                        run_reg   <= st_run;
                        rs_reg    <= st_rs;
                        found_reg <= st_f;
                        best_reg  <= st_b;
                        bs_reg    <= st_bs;
                    end
                    if (fit_reg == FIT_NEXT && pend_reg && st_f) begin
                        pend_reg <= 1'b0;
                        if (pass2_reg && st_bs >= cursor_reg) begin
                            ok_reg    <= 1'b0;
                            state_reg <= ST_DONE;
                        end else begin
                            start_reg <= st_bs;
                            mw_reg    <= WAW'(st_bs >> MWB);
                            state_reg <= ST_MARK_RD;
                        end
                    end else if (a_reg < (WAW+1)'(WORDS)) begin
                        e_reg    <= a_reg[WAW-1:0];
                        a_reg    <= a_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end else if (pend_reg) begin
                        pend_reg <= 1'b0;
                    end else if (fit_reg == FIT_BEST) begin
                        if (found_reg || best_take) begin
                            start_reg <= best_take ? rs_reg : bs_reg;
                            mw_reg    <= best_take ? WAW'(rs_reg >> MWB)
                                                   : WAW'(bs_reg >> MWB);
                            state_reg <= ST_MARK_RD;
                        end else begin
                            ok_reg    <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                    end else if (!pass2_reg) begin
                        // wrap: second pass from page 0
                        pass2_reg <= 1'b1;
                        a_reg     <= '0;
                        lo_reg    <= '0;
                        run_reg   <= '0;
                    end else begin
                        ok_reg    <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_MARK_RD: state_reg <= ST_MARK_WR;
                ST_MARK_WR: begin
                    if (mark_last) begin
                        state_reg <= ST_REC_WR;
                    end else begin
                        mw_reg    <= mw_reg + 1'b1;
                        state_reg <= ST_MARK_RD;
                    end
                end
                ST_REC_WR: begin
                    if (op_reg == OP_ALLOC && fit_reg == FIT_NEXT) begin
                        cursor_reg <= (cur_sum >= IW'(HEAP_PAGES)) ? '0 : cur_sum[PW-1:0];
                    end
                    ok_reg    <= 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        out_ok_reg   <= ok_reg;
                        out_addr_reg <= ok_reg ? (base_reg + (32'(start_reg) << PB)) : '0;
                        out_cnt_reg  <= ok_reg ? cnt_reg : '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // assertion helpers
    logic res_zero, cnt_good, cursor_in;
    assign res_zero  = (out_addr_reg == '0) && (out_cnt_reg == '0);
    assign cnt_good  = (out_cnt_reg != '0) && (out_cnt_reg <= CW'(HEAP_PAGES));
    assign cursor_in = IW'(cursor_reg) < IW'(HEAP_PAGES);

    `PRA_ASSERT(a_fail_zero, m_tvalid && !out_ok_reg |-> res_zero, "failed result not all zero")
    `PRA_ASSERT(a_ok_count, m_tvalid && out_ok_reg |-> cnt_good, "bad page count on success")
    `PRA_ASSERT_ALWAYS(a_cursor, !aresetn || cursor_in, "next-fit cursor outside heap")
    `PRA_ASSERT(a_clear_block, state_reg == ST_CLEAR |-> !s_tready, "input taken while clearing")
    `PRA_ASSERT(a_mark_range, state_reg == ST_MARK_WR |-> mark_mask != '0, "empty bitmap write")
endmodule
